[hdl/istc_pkg.sv]
// Shared types and constants for the IMU sample scaler and tilt core.
// Used by istc_front, istc_queue, istc_back and the top level.
// No dependencies.
`timescale 1ns / 1ps

package istc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TILT_STEPS      = 24;
    localparam int SQRT_STEPS      = 24;
    localparam int TILT_LIMIT      = 9000;
    localparam int IN_W            = 112;
    localparam int OUT_W           = 144;

    // Reciprocals for the constant divisions (floor(m * C >> K) == floor(m / D)).
    localparam int unsigned TEMP_RECIP = 246724;   // 2^22 / 17, rounded up
    localparam int unsigned TEMP_SHIFT = 22;
    localparam int unsigned RATE_RECIP = 8196503;  // 2^30 / 131, rounded up
    localparam int unsigned RATE_SHIFT = 30;

    // atan(2^-i) in 1/65536 of a hundredth of a degree
    localparam logic signed [31:0] ATAN_TAB [TILT_STEPS] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45
    };

    typedef struct packed {
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] temperature;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } raw_t;

    typedef struct packed {
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [14:0] temp;
        logic signed [11:0] accel_z;
        logic signed [11:0] accel_y;
        logic signed [11:0] accel_x;
    } scaled_t;

    // One request handed from the front end to the tilt engine.
    // Lane 0/1/2 is the tilt of x/y/z: sq holds the sum of the other two squares.
    typedef struct packed {
        scaled_t          scaled;
        logic [2:0][31:0] sq;
        logic [2:0][15:0] axis;
        logic             zero;
    } qitem_t;

endpackage

[hdl/imu_sample_scale_and_tilt_core.sv]
// Top level of the IMU sample scaler and tilt core.
// Depends on istc_pkg, istc_front, istc_queue and istc_back.
//
//  channel | ports                       | content
//  --------+-----------------------------+---------------------------------------
//  in      | s_tvalid s_tready s_tdata   | one raw sample, seven 16-bit readings
//  out     | m_tvalid m_tready m_tdata   | scaled sample plus three tilt angles
//
// One request is taken every clock while the result side keeps up.
// The path runs through three front stages, the queue, the tilt engine input register,
// 24 square-root stages, the CORDIC load register, 24 CORDIC stages and the final
// tilt register.
// Reset is synchronous, active low; it clears valid flags, queue pointers and fill count only.
// A stalled output freezes the back pipeline; the front keeps filling the queue until it is full.
`timescale 1ns / 1ps

module imu_sample_scale_and_tilt_core #(
    parameter int QUEUE_DEPTH = istc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_temperature,
    // raw_rate_x, raw_rate_y, raw_rate_z (16 bits each, lowest first)
    input  logic [istc_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // accel_x/y/z_milli_g (12 each), temperature_centi (15),
    // rate_x/y/z_centi (16 each), tilt_x/y/z_centi (15 each), lowest first
    output logic [istc_pkg::OUT_W-1:0] m_tdata
);

    istc_pkg::raw_t    raw;
    istc_pkg::qitem_t  f_item, q_item;
    logic              f_valid, f_ready;
    logic              q_valid, q_ready;
    istc_pkg::scaled_t res;
    logic signed [14:0] tilt [3];

    // seven readings unpacked straight from the bus word
    assign raw.accel_x     = s_tdata[15:0];
    assign raw.accel_y     = s_tdata[31:16];
    assign raw.accel_z     = s_tdata[47:32];
    assign raw.temperature = s_tdata[63:48];
    assign raw.rate_x      = s_tdata[79:64];
    assign raw.rate_y      = s_tdata[95:80];
    assign raw.rate_z      = s_tdata[111:96];

    istc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_raw    (raw),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    istc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    istc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_scaled (res),
        .out_tilt   (tilt)
    );

    // result word, first field in the lowest bits
    assign m_tdata = {tilt[2], tilt[1], tilt[0],
                      res.rate_z, res.rate_y, res.rate_x, res.temp,
                      res.accel_z, res.accel_y, res.accel_x};

endmodule

[hdl/istc_front.sv]
// Front end: registers the sample, does the unit scalings and the squares.
// Depends on istc_pkg.
`timescale 1ns / 1ps

module istc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  istc_pkg::raw_t  in_raw,
    output logic            out_valid,
    input  logic            out_ready,
    output istc_pkg::qitem_t out_item
);

    logic [2:0] vld_reg;
    logic       adv;

    // stage 1
    istc_pkg::raw_t raw_reg;

    // stage 2
    logic signed [25:0] accp_reg [3];
    logic [17:0]        tmag_reg;
    logic               tneg_reg;
    logic [21:0]        rmag_reg [3];
    logic               rneg_reg [3];
    logic [30:0]        sqr_reg  [3];
    logic [15:0]        axis2_reg [3];
    logic               zero2_reg;

    // stage 3
    logic signed [11:0] acc_reg [3];
    logic [13:0]        tq_reg;
    logic               tneg3_reg;
    logic [14:0]        rq_reg [3];
    logic               rneg3_reg [3];
    logic [31:0]        sum_reg [3];
    logic [15:0]        axis3_reg [3];
    logic               zero3_reg;

    logic signed [15:0] raw_acc  [3];
    logic signed [15:0] raw_rate [3];
    logic signed [16:0] t_off;
    logic signed [18:0] t_p5;
    logic [15:0]        acc_abs  [3];
    logic [15:0]        rate_abs [3];
    logic [31:0]        sq_full  [3];
    logic signed [25:0] acc_bias [3];
    logic [35:0]        t_prod;
    logic [44:0]        r_prod   [3];

    assign adv       = !vld_reg[2] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[2];

    always_comb begin
        raw_acc[0]  = raw_reg.accel_x;
        raw_acc[1]  = raw_reg.accel_y;
        raw_acc[2]  = raw_reg.accel_z;
        raw_rate[0] = raw_reg.rate_x;
        raw_rate[1] = raw_reg.rate_y;
        raw_rate[2] = raw_reg.rate_z;
        t_off = 17'(raw_reg.temperature) + 17'sd12412;
        t_p5  = (19'(t_off) <<< 2) + 19'(t_off);
        for (int l = 0; l < 3; l++) begin
            acc_abs[l]  = raw_acc[l][15]  ? 16'(-raw_acc[l])  : raw_acc[l];
            rate_abs[l] = raw_rate[l][15] ? 16'(-raw_rate[l]) : raw_rate[l];
            sq_full[l]  = 32'(acc_abs[l]) * 32'(acc_abs[l]);
            acc_bias[l] = accp_reg[l] + (accp_reg[l][25] ? 26'sd16383 : 26'sd0);
            r_prod[l]   = 45'(rmag_reg[l]) * 45'(istc_pkg::RATE_RECIP);
        end
        t_prod = 36'(tmag_reg) * 36'(istc_pkg::TEMP_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            raw_reg <= in_raw;

            tneg_reg  <= t_p5[18];
            tmag_reg  <= t_p5[18] ? 18'(-t_p5) : 18'(t_p5);
            zero2_reg <= (raw_acc[0] == 16'sd0) && (raw_acc[1] == 16'sd0) &&
                         (raw_acc[2] == 16'sd0);
            for (int l = 0; l < 3; l++) begin
                accp_reg[l]  <= 26'(raw_acc[l]) * 26'sd1000;
                rneg_reg[l]  <= raw_rate[l][15];
                rmag_reg[l]  <= 22'(rate_abs[l]) * 22'd100;
                sqr_reg[l]   <= sq_full[l][30:0];
                axis2_reg[l] <= raw_acc[l];
            end

            tq_reg    <= 14'(t_prod >> istc_pkg::TEMP_SHIFT);
            tneg3_reg <= tneg_reg;
            zero3_reg <= zero2_reg;
            sum_reg[0] <= 32'(sqr_reg[1]) + 32'(sqr_reg[2]);
            sum_reg[1] <= 32'(sqr_reg[0]) + 32'(sqr_reg[2]);
            sum_reg[2] <= 32'(sqr_reg[0]) + 32'(sqr_reg[1]);
            for (int l = 0; l < 3; l++) begin
                acc_reg[l]   <= acc_bias[l][25:14];
                rq_reg[l]    <= 15'(r_prod[l] >> istc_pkg::RATE_SHIFT);
                rneg3_reg[l] <= rneg_reg[l];
                axis3_reg[l] <= axis2_reg[l];
            end
        end
    end

    always_comb begin
        out_item.scaled.accel_x = acc_reg[0];
        out_item.scaled.accel_y = acc_reg[1];
        out_item.scaled.accel_z = acc_reg[2];
        out_item.scaled.temp    = tneg3_reg ? -15'(tq_reg) : 15'(tq_reg);
        out_item.scaled.rate_x  = rneg3_reg[0] ? -16'(rq_reg[0]) : 16'(rq_reg[0]);
        out_item.scaled.rate_y  = rneg3_reg[1] ? -16'(rq_reg[1]) : 16'(rq_reg[1]);
        out_item.scaled.rate_z  = rneg3_reg[2] ? -16'(rq_reg[2]) : 16'(rq_reg[2]);
        for (int l = 0; l < 3; l++) begin
            out_item.sq[l]   = sum_reg[l];
            out_item.axis[l] = axis3_reg[l];
        end
        out_item.zero = zero3_reg;
    end

endmodule

[hdl/istc_queue.sv]
// Short queue between the front end and the tilt engine.
// Depends on istc_pkg.
`timescale 1ns / 1ps

module istc_queue #(
    parameter int DEPTH = istc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  istc_pkg::qitem_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output istc_pkg::qitem_t out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    istc_pkg::qitem_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill beyond depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill did not rise on write");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue fill did not fall on read");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_reg == rd_reg))
        else $error("queue pointers differ while empty");

endmodule

[hdl/istc_back.sv]
// Tilt engine: pipelined square root then pipelined vectoring CORDIC, three lanes.
// Depends on istc_pkg.
`timescale 1ns / 1ps

module istc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  istc_pkg::qitem_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output istc_pkg::scaled_t out_scaled,
    output logic signed [14:0] out_tilt [3]
);

    localparam int SQ_N = istc_pkg::SQRT_STEPS;
    localparam int CO_N = istc_pkg::TILT_STEPS;
    localparam int NTOT = SQ_N + CO_N + 3;
    localparam int CO_B = SQ_N + 1;          // first CORDIC bank
    localparam int LASTC = CO_B + CO_N;      // last CORDIC bank

    typedef struct packed {
        logic [31:0] rad;
        logic [25:0] rem;
        logic [23:0] root;
    } root_t;

    typedef struct packed {
        logic signed [26:0] x;
        logic signed [26:0] y;
        logic signed [31:0] z;
    } cord_t;

    function automatic root_t sqrt_step(input root_t s);
        root_t       r;
        logic [27:0] rem_sh;
        logic [27:0] trial;
        logic [27:0] diff;
        rem_sh = {s.rem, s.rad[31:30]};
        trial  = {2'b00, s.root, 2'b01};
        diff   = rem_sh - trial;
        r.rad  = {s.rad[29:0], 2'b00};
        if (rem_sh >= trial) begin
            r.rem  = diff[25:0];
            r.root = {s.root[22:0], 1'b1};
        end else begin
            r.rem  = rem_sh[25:0];
            r.root = {s.root[22:0], 1'b0};
        end
        return r;
    endfunction

    function automatic cord_t cordic_step(input cord_t c, input int i);
        cord_t              r;
        logic signed [26:0] dx;
        logic signed [26:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.y[26]) begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + istc_pkg::ATAN_TAB[i];
        end else begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - istc_pkg::ATAN_TAB[i];
        end
        return r;
    endfunction

    function automatic logic signed [14:0] tilt_of(input logic signed [31:0] z,
                                                   input logic zero);
        logic [31:0] az;
        logic [15:0] mag;
        logic [14:0] m15;
        az  = z[31] ? 32'(-z) : 32'(z);
        mag = az[31:16];
        m15 = (mag > 16'(istc_pkg::TILT_LIMIT)) ? 15'(istc_pkg::TILT_LIMIT) : mag[14:0];
        if (zero) begin
            return '0;
        end
        return z[31] ? -$signed(m15) : $signed(m15);
    endfunction

    logic [NTOT-1:0]   vld_reg;
    logic              adv;
    istc_pkg::scaled_t pay_reg  [NTOT];
    logic              zero_reg [NTOT];
    root_t             rt_reg   [SQ_N+1][3];
    logic [15:0]       axis_reg [SQ_N+1][3];
    cord_t             co_reg   [CO_N+1][3];
    logic signed [14:0] tilt_reg [3];

    assign adv        = !vld_reg[NTOT-1] || out_ready;
    assign in_ready   = adv;
    assign out_valid  = vld_reg[NTOT-1];
    assign out_scaled = pay_reg[NTOT-1];
    assign out_tilt   = tilt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NTOT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay_reg[0]  <= in_item.scaled;
            zero_reg[0] <= in_item.zero;
            for (int k = 1; k < NTOT; k++) begin
                pay_reg[k]  <= pay_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            for (int l = 0; l < 3; l++) begin
                rt_reg[0][l]   <= '{rad: in_item.sq[l], rem: '0, root: '0};
                axis_reg[0][l] <= in_item.axis[l];
                for (int j = 1; j <= SQ_N; j++) begin
                    rt_reg[j][l]   <= sqrt_step(rt_reg[j-1][l]);
                    axis_reg[j][l] <= axis_reg[j-1][l];
                end
                // magnitude with 8 fraction bits against axis scaled by 2^8
                co_reg[0][l] <= '{x: {3'b000, rt_reg[SQ_N][l].root},
                                  y: {{3{axis_reg[SQ_N][l][15]}}, axis_reg[SQ_N][l], 8'h00},
                                  z: '0};
                for (int i = 1; i <= CO_N; i++) begin
                    co_reg[i][l] <= cordic_step(co_reg[i-1][l], i - 1);
                end
                tilt_reg[l] <= tilt_of(co_reg[CO_N][l].z, zero_reg[LASTC]);
            end
        end
    end

endmodule
